// File: rtl/core/length_prefixed_packet_deframer_unit_assert.svh
// Assertion macros for the length-prefixed packet deframer.
// Used by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define LPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
// next-cycle implication
`define LPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`else
`define LPD_ASSERT_NOW(label, ante, cons)
`define LPD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/lpd_pkg.sv
// Shared types and constants for the length-prefixed packet deframer.
// No dependencies.
`default_nettype none

package lpd_pkg;

  localparam logic [7:0]  SYNC_FIRST  = 8'hEE;
  localparam logic [7:0]  SYNC_SECOND = 8'hAD;
  localparam logic [15:0] ID_BYTES    = 16'd4;

  // header byte positions
  localparam logic [1:0] HDR_SYNC0 = 2'd0;
  localparam logic [1:0] HDR_SYNC1 = 2'd1;
  localparam logic [1:0] HDR_LENHI = 2'd2;
  localparam logic [1:0] HDR_LENLO = 2'd3;

  localparam logic [1:0] PHASE_HEADER  = 2'd0;
  localparam logic [1:0] PHASE_ID      = 2'd1;
  localparam logic [1:0] PHASE_PAYLOAD = 2'd2;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_BAD_SYNC = 2'd2;
  localparam logic [1:0] KIND_SHORT    = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] message_id;
    logic [7:0]  payload_byte;
    logic        last;
  } lpd_result_t;

endpackage

`default_nettype wire

// File: rtl/core/lpd_parser.sv
// Per-byte phase machine of the deframer: header, id and payload tracking.
// Depends on lpd_pkg.
`default_nettype none

module lpd_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [7:0]         data_byte,
  output lpd_pkg::lpd_result_t    res
);
  import lpd_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [15:0] byte_count, byte_count_next;
  logic        sync_good, sync_good_next;
  logic [15:0] packet_length, packet_length_next;
  logic [31:0] id_register, id_register_next;

  logic [15:0] count_inc;
  logic [15:0] remaining;
  logic [15:0] len_full;

  assign count_inc = byte_count + 16'd1;
  assign remaining = packet_length - ID_BYTES;
  assign len_full  = {packet_length[15:8], data_byte};

  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    sync_good_next     = sync_good;
    packet_length_next = packet_length;
    id_register_next   = id_register;
    res                = '0;

    unique case (phase)
      PHASE_ID: begin
        unique case (byte_count[1:0])
          2'd0: id_register_next[7:0]   = data_byte;
          2'd1: id_register_next[15:8]  = data_byte;
          2'd2: id_register_next[23:16] = data_byte;
          2'd3: id_register_next[31:24] = data_byte;
          default: id_register_next = id_register;
        endcase
        if (byte_count[1:0] == 2'd3) begin
          if (packet_length == ID_BYTES) begin
            res.valid      = 1'b1;
            res.kind       = KIND_EMPTY;
            res.message_id = id_register_next;
            res.last       = 1'b1;
            phase_next     = PHASE_HEADER;
            sync_good_next = 1'b1;
          end else begin
            phase_next = PHASE_PAYLOAD;
          end
          byte_count_next = '0;
        end else begin
          byte_count_next = count_inc;
        end
      end

      PHASE_PAYLOAD: begin
        res.valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.message_id   = id_register;
        res.payload_byte = data_byte;
        res.last         = (count_inc >= remaining);
        if (res.last) begin
          phase_next      = PHASE_HEADER;
          byte_count_next = '0;
          sync_good_next  = 1'b1;
        end else begin
          byte_count_next = count_inc;
        end
      end

      default: begin
        // header phase; the unused code restarts a header at its first byte
        logic [1:0] hpos;
        hpos = (phase == PHASE_HEADER) ? byte_count[1:0] : HDR_SYNC0;
        phase_next      = PHASE_HEADER;
        byte_count_next = {14'd0, hpos} + 16'd1;
        unique case (hpos)
          HDR_SYNC0: sync_good_next     = (data_byte == SYNC_FIRST);
          HDR_SYNC1: sync_good_next     = sync_good && (data_byte == SYNC_SECOND);
          HDR_LENHI: packet_length_next = {data_byte, 8'h00};
          HDR_LENLO: begin
            packet_length_next = len_full;
            byte_count_next    = '0;
            if (!sync_good) begin
              res.valid      = 1'b1;
              res.kind       = KIND_BAD_SYNC;
              res.last       = 1'b1;
              sync_good_next = 1'b1;
            end else if (len_full < ID_BYTES) begin
              res.valid      = 1'b1;
              res.kind       = KIND_SHORT;
              res.last       = 1'b1;
              sync_good_next = 1'b1;
            end else begin
              phase_next       = PHASE_ID;
              id_register_next = '0;
            end
          end
          default: sync_good_next = sync_good;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PHASE_HEADER;
      byte_count    <= '0;
      sync_good     <= 1'b1;
      packet_length <= '0;
      id_register   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      sync_good     <= sync_good_next;
      packet_length <= packet_length_next;
      id_register   <= id_register_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/length_prefixed_packet_deframer_unit.sv
// Top level of the length-prefixed packet deframer: input register, parser, result register.
// Depends on lpd_pkg, lpd_parser and length_prefixed_packet_deframer_unit_assert.svh.
//
//  channel | dir | signals                          | contents
//  --------+-----+----------------------------------+-------------------------------
//  s_      | in  | tvalid tready tdata[7:0]         | one stream byte per beat
//  m_      | out | tvalid tready tdata tuser tlast  | payload byte / packet event
//
// Throughput: one byte per cycle sustained while m_ is not stalled. A byte accepted on s_
// is held in the input register and parsed as it advances; any result is registered onto m_.
// Two register stages (input byte, result) each take a new beat when their own
// downstream slot is free, so a stalled m_ side holds two beats before s_tready falls.
// Reset (rst, synchronous, active high) returns the parser to header hunting with
// no beats held. A packet that never completes simply waits; there is no timeout.
`default_nettype none

module length_prefixed_packet_deframer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,   // [31:0] message_id, [39:32] payload_byte
  output      logic [1:0]  m_tuser,   // [1:0] kind
  output      logic        m_tlast
);
  import lpd_pkg::*;

  // input stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;     // input beat moves through the parser this cycle

  lpd_result_t res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  lpd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .res       (res)
  );

  // result register; a byte with no result still advances but leaves it empty
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {res.payload_byte, res.message_id};
      m_tuser <= res.kind;
      m_tlast <= res.last;
    end
  end

`include "length_prefixed_packet_deframer_unit_assert.svh"

  // anything other than a payload byte closes its packet or is an error
  `LPD_ASSERT_NOW(a_event_last, m_tvalid && (m_tuser != KIND_PAYLOAD), m_tlast)
  // header errors carry neither id nor payload
  `LPD_ASSERT_NOW(a_err_zero, m_tvalid && (m_tuser == KIND_BAD_SYNC || m_tuser == KIND_SHORT), m_tdata == 40'd0)
  // a held input byte is never dropped while the result side stalls
  `LPD_ASSERT_NEXT(a_in_hold, in_valid && !advance, in_valid && $stable(in_byte))

endmodule

`default_nettype wire

// File: tb/lpd_checker.sv
// Scoreboard for the length-prefixed packet deframer: watches both stream channels,
// predicts each result beat from the accepted bytes and compares field by field.
// Depends on lpd_pkg.
module lpd_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        m_tlast,
  output int               mismatches,
  output int               outstanding
);
  import lpd_pkg::*;

  localparam logic [15:0] HEADER_BYTES = 16'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] message_id;
    logic [7:0]  payload_byte;
    logic        last;
  } frame_beat_t;

  frame_beat_t expected_beats[$];
  int          fail_tally = 0;

  // deframer state as seen by the predictor
  logic [1:0]  phase;
  logic [15:0] byte_count;
  logic        sync_good;
  logic [15:0] packet_length;
  logic [31:0] id_reg;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void hunt_header();
    phase      = PHASE_HEADER;
    byte_count = 16'd0;
    sync_good  = 1'b1;
  endfunction

  // Advance the deframer by one byte; returns 1 when a result beat is due.
  function automatic bit deframe_byte(input logic [7:0] b, output frame_beat_t res);
    res = '0;
    if (phase == PHASE_ID) begin
      id_reg[8*byte_count[1:0] +: 8] = b;   // little-endian id
      byte_count = byte_count + 16'd1;
      if (byte_count < ID_BYTES) return 1'b0;
      if (packet_length == ID_BYTES) begin
        res = '{KIND_EMPTY, id_reg, 8'h00, 1'b1};
        hunt_header();
        return 1'b1;
      end
      phase      = PHASE_PAYLOAD;
      byte_count = 16'd0;
      return 1'b0;
    end
    if (phase == PHASE_PAYLOAD) begin
      byte_count = byte_count + 16'd1;
      res = '{KIND_PAYLOAD, id_reg, b, byte_count >= (packet_length - ID_BYTES)};
      if (res.last) hunt_header();
      return 1'b1;
    end
    // header phase; the spare phase code restarts the header
    if (phase != PHASE_HEADER) hunt_header();
    if (byte_count == {14'd0, HDR_SYNC0}) sync_good = (b == SYNC_FIRST);
    else if (byte_count == {14'd0, HDR_SYNC1}) sync_good = sync_good && (b == SYNC_SECOND);
    else if (byte_count == {14'd0, HDR_LENHI}) packet_length = {b, 8'h00};
    else packet_length = {packet_length[15:8], b};
    byte_count = byte_count + 16'd1;
    if (byte_count < HEADER_BYTES) return 1'b0;
    if (!sync_good) begin
      res = '{KIND_BAD_SYNC, 32'd0, 8'h00, 1'b1};
      hunt_header();
      return 1'b1;
    end
    if (packet_length < ID_BYTES) begin
      res = '{KIND_SHORT, 32'd0, 8'h00, 1'b1};
      hunt_header();
      return 1'b1;
    end
    phase      = PHASE_ID;
    byte_count = 16'd0;
    id_reg     = 32'd0;
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    frame_beat_t got;
    frame_beat_t want;
    if (rst) begin
      hunt_header();
      packet_length = 16'd0;
      id_reg        = 32'd0;
      expected_beats.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tuser, m_tdata[31:0], m_tdata[39:32], m_tlast};
        if (expected_beats.size() == 0) begin
          $error("unexpected beat: kind %0d id %h byte %h last %0d",
                 got.kind, got.message_id, got.payload_byte, got.last);
          fail_tally++;
        end else begin
          want = expected_beats.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            fail_tally++;
          end
          if (got.message_id !== want.message_id) begin
            $error("message_id: expected %h, got %h", want.message_id, got.message_id);
            fail_tally++;
          end
          if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %h, got %h", want.payload_byte, got.payload_byte);
            fail_tally++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            fail_tally++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (deframe_byte(s_tdata, want)) expected_beats.push_back(want);
      end
    end
    mismatches  <= fail_tally;
    outstanding <= expected_beats.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top for the length-prefixed packet deframer: byte stimulus, paced receiver,
// stall watchdog and verdict. Depends on lpd_pkg, lpd_checker and the deframer top level.
module tb;
  import lpd_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no beat on either side
  localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, forces input back-pressure
  localparam int DRAIN_CYCLES    = 32;
  localparam int STREAM_TARGET   = 1940;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        m_tready = 1'b0;
  wire logic        s_tready;
  wire logic        m_tvalid;
  wire logic [39:0] m_tdata;
  wire logic [1:0]  m_tuser;
  wire logic        m_tlast;

  int         mismatches;
  int         outstanding;
  int         idle_cycles = 0;
  logic [7:0] stream_bytes[$];

  length_prefixed_packet_deframer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  lpd_checker deframe_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] other_than(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == avoid) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic push_header(input logic [7:0] s0, input logic [7:0] s1,
                             input logic [15:0] len);
    stream_bytes.push_back(s0);
    stream_bytes.push_back(s1);
    stream_bytes.push_back(len[15:8]);   // length is big-endian
    stream_bytes.push_back(len[7:0]);
  endtask

  // well-formed packet with random payload; len >= 4
  task automatic push_packet(input logic [15:0] len, input logic [31:0] id);
    push_header(SYNC_FIRST, SYNC_SECOND, len);
    for (int k = 0; k < 4; k++) stream_bytes.push_back(id[8*k +: 8]);
    repeat (int'(len) - 4) stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_stream();
    int         pick;
    int         flavour;
    logic [15:0] len;
    logic [7:0] s0;
    logic [7:0] s1;
    // directed: empty packet with all-ones id, one-byte packet, bad first sync, zero length
    push_packet(16'd4, 32'hFFFF_FFFF);
    push_header(SYNC_FIRST, SYNC_SECOND, 16'd5);
    repeat (4) stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    push_header(8'h00, SYNC_SECOND, 16'hFFFF);
    push_header(SYNC_FIRST, SYNC_SECOND, 16'd0);
    // random: mostly good packets, some header errors and noise groups
    while (stream_bytes.size() < STREAM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 59) == 0) len = 16'($urandom_range(250, 300));
        else len = 16'($urandom_range(4, 20));
        push_packet(len, $urandom());
      end else if (pick < 80) begin
        flavour = $urandom_range(0, 2);
        s0 = (flavour != 1) ? other_than(SYNC_FIRST) : SYNC_FIRST;
        s1 = (flavour != 0) ? other_than(SYNC_SECOND) : SYNC_SECOND;
        push_header(s0, s1, 16'($urandom_range(0, 65535)));
      end else if (pick < 88) begin
        push_header(SYNC_FIRST, SYNC_SECOND, 16'($urandom_range(0, 3)));
      end else begin
        // noise group, kept header-aligned so framing is not lost
        push_header(other_than(SYNC_FIRST), 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)));
      end
    end
    // packet left incomplete at the end: the deframer just waits
    push_header(SYNC_FIRST, SYNC_SECOND, 16'd12);
    stream_bytes.push_back(8'($urandom_range(0, 255)));
    stream_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // sender
  initial begin
    int gap;
    bit steady;
    steady = 1'b0;
    build_stream();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (stream_bytes[i]) begin
      if ($urandom_range(0, 29) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= stream_bytes[i];
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random pacing, plus two long stalls to back the block up
  initial begin
    int gap;
    int beats_taken;
    bit steady;
    steady      = 1'b0;
    beats_taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 19);
      if (beats_taken == 40 || beats_taken == 700) gap = HOLD_OFF_CYCLES;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      beats_taken++;
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

// File: length_prefixed_packet_deframer_unit.f
+incdir+rtl/core
rtl/core/lpd_pkg.sv
rtl/core/lpd_parser.sv
rtl/core/length_prefixed_packet_deframer_unit.sv
tb/lpd_checker.sv
tb/tb.sv
